FILE: sv/tsd_pkg.sv
// tsd_pkg: shared types and constants for the tga stream decoder
// no dependencies; used by every module of the decoder
package tsd_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_INFO,
    PH_RAW,
    PH_PKTHDR,
    PH_PKTDATA,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    KIND_INFO  = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  localparam logic [1:0] ERR_HEADER    = 2'd0;
  localparam logic [1:0] ERR_SIZE      = 2'd1;
  localparam logic [1:0] ERR_TRUNCATED = 2'd2;
  localparam logic [1:0] ERR_OVERRUN   = 2'd3;

  localparam logic [1:0] FMT_RGB24  = 2'd0;
  localparam logic [1:0] FMT_RGBA32 = 2'd1;
  localparam logic [1:0] FMT_ALPHA8 = 2'd2;

  localparam logic [7:0] TYPE_RGB      = 8'd2;
  localparam logic [7:0] TYPE_GRAY     = 8'd3;
  localparam logic [7:0] TYPE_RLE_RGB  = 8'd10;
  localparam logic [7:0] TYPE_RLE_GRAY = 8'd11;
  localparam logic [7:0] DEPTH_24      = 8'd24;
  localparam logic [7:0] DEPTH_32      = 8'd32;
  localparam logic [7:0] DEPTH_8       = 8'd8;

  localparam int OUT_DATA_W = 80;

  // one classified result, as it travels from front to back
  typedef struct packed {
    kind_t           kind;
    logic [1:0]      code;
    logic [15:0]     width;
    logic [15:0]     height;
    logic [1:0]      fmt;
    logic            comp;
    logic [3:0][7:0] pix;
    logic [2:0]      bpp;
    logic [7:0]      count;
    logic            last;
  } rec_t;

endpackage

FILE: sv/tga_stream_decoder.sv
// tga_stream_decoder: top level of the tga byte-stream decoder
// depends on tsd_pkg, tsd_front, tsd_queue, tsd_back
//
// Takes one file byte per cycle (tlast on the final byte) and returns info,
// pixel/run and error results. Every byte is parsed combinationally by the
// front parser, including the width-times-height multiply on the last info byte;
// results pass through a QUEUE_DEPTH-entry queue into a registered output
// stage, so the input keeps flowing while results wait, until the queue fills.
module tga_stream_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // data_byte
  input  logic                           in_tlast,   // last_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // image_width[15:0] image_height[31:16] pixel_format[33:32] is_compressed[34]
  // first[42:35] second[50:43] third[58:51] fourth[66:59] run_length[74:67]
  // error_code[76:75], zero pad
  output logic [tsd_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                     out_tuser,  // result_kind
  output logic                           out_tlast   // last_pixel
);
  import tsd_pkg::*;

  logic acc, rec_valid, full, empty, take;
  rec_t rec, head_rec;

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  tsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  tsd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (acc && rec_valid),
    .push_rec (rec),
    .pop      (take),
    .full     (full),
    .empty    (empty),
    .head_rec (head_rec)
  );

  tsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .have_rec   (!empty),
    .rec        (head_rec),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: sv/tsd_front.sv
// tsd_front: byte parser; tracks header, info and packet state and
// produces at most one result record per byte. depends on tsd_pkg
module tsd_front (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        rec_valid,
  output tsd_pkg::rec_t rec
);
  import tsd_pkg::*;

  phase_t          phase_r, phase_nxt;
  logic [3:0]      idx_r, idx_nxt;
  logic            hdr_ok_r, hdr_ok_nxt;
  logic            comp_r, comp_nxt;
  logic [15:0]     width_r, width_nxt;
  logic [15:0]     height_r, height_nxt;
  logic [2:0]      bpp_r, bpp_nxt;
  logic [31:0]     left_r, left_nxt;
  logic [7:0]      pkt_r, pkt_nxt;
  logic            run_r, run_nxt;
  logic [3:0][7:0] pix_r, pix_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      idx_r    <= '0;
      hdr_ok_r <= 1'b1;
      comp_r   <= 1'b0;
      width_r  <= '0;
      height_r <= '0;
      bpp_r    <= '0;
      left_r   <= '0;
      pkt_r    <= '0;
      run_r    <= 1'b0;
      pix_r    <= '0;
    end else if (acc) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      hdr_ok_r <= hdr_ok_nxt;
      comp_r   <= comp_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      bpp_r    <= bpp_nxt;
      left_r   <= left_nxt;
      pkt_r    <= pkt_nxt;
      run_r    <= run_nxt;
      pix_r    <= pix_nxt;
    end
  end

  always_comb begin
    logic [3:0]  idx_inc;
    logic [7:0]  cnt;
    logic [31:0] left_sub;
    idx_inc    = idx_r + 4'd1;
    cnt        = 8'd1;
    left_sub   = '0;
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    hdr_ok_nxt = hdr_ok_r;
    comp_nxt   = comp_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    bpp_nxt    = bpp_r;
    left_nxt   = left_r;
    pkt_nxt    = pkt_r;
    run_nxt    = run_r;
    pix_nxt    = pix_r;
    rec_valid  = 1'b0;
    rec        = '0;
    rec.kind   = KIND_INFO;

    unique case (phase_r)
      PH_HEADER: begin
        if (idx_r == 4'd2) begin
          if (data_byte == TYPE_RLE_RGB || data_byte == TYPE_RLE_GRAY) comp_nxt = 1'b1;
          else if (data_byte != TYPE_RGB && data_byte != TYPE_GRAY) hdr_ok_nxt = 1'b0;
        end else if (data_byte != 8'd0) begin
          hdr_ok_nxt = 1'b0;
        end
        if (idx_r >= 4'd11) begin
          idx_nxt = '0;
          if (hdr_ok_nxt) begin
            phase_nxt = PH_INFO;
          end else begin
            phase_nxt = PH_ERROR;
            rec_valid = 1'b1;
            rec.kind  = KIND_ERROR;
            rec.code  = ERR_HEADER;
          end
        end else begin
          idx_nxt = idx_inc;
        end
      end
      PH_INFO: begin
        unique case (idx_r)
          4'd0: width_nxt  = {8'd0, data_byte};
          4'd1: width_nxt  = {data_byte, width_r[7:0]};
          4'd2: height_nxt = {8'd0, data_byte};
          4'd3: height_nxt = {data_byte, height_r[7:0]};
          4'd4: begin
            if (data_byte == DEPTH_24) bpp_nxt = 3'd3;
            else if (data_byte == DEPTH_32) bpp_nxt = 3'd4;
            else if (data_byte == DEPTH_8 && !comp_r) bpp_nxt = 3'd1;
            else bpp_nxt = 3'd0;
          end
          default: ;
        endcase
        if (idx_r >= 4'd5) begin
          idx_nxt   = '0;
          rec_valid = 1'b1;
          if (width_r == '0 || height_r == '0 || bpp_r == '0) begin
            phase_nxt = PH_ERROR;
            rec.kind  = KIND_ERROR;
            rec.code  = ERR_SIZE;
          end else begin
            // the one header multiply
            left_nxt   = width_r * height_r;
            rec.kind   = KIND_INFO;
            rec.width  = width_r;
            rec.height = height_r;
            rec.fmt    = (bpp_r == 3'd3) ? FMT_RGB24 :
                         (bpp_r == 3'd4) ? FMT_RGBA32 : FMT_ALPHA8;
            rec.comp   = comp_r;
            phase_nxt  = comp_r ? PH_PKTHDR : PH_RAW;
          end
        end else begin
          idx_nxt = idx_inc;
        end
      end
      PH_RAW, PH_PKTDATA: begin
        pix_nxt[idx_r[1:0]] = data_byte;
        idx_nxt = idx_inc;
        if (idx_inc >= {1'b0, bpp_r}) begin
          idx_nxt = '0;
          if (phase_r == PH_PKTDATA) begin
            if (run_r) begin
              cnt     = pkt_r;
              pkt_nxt = '0;
            end else begin
              pkt_nxt = pkt_r - 8'd1;
            end
          end
          left_sub  = left_r - {24'd0, cnt};
          left_nxt  = left_sub;
          rec_valid = 1'b1;
          rec.kind  = KIND_PIXEL;
          rec.pix   = pix_nxt;
          rec.bpp   = bpp_r;
          rec.count = cnt;
          if (left_sub == '0) begin
            rec.last  = 1'b1;
            phase_nxt = PH_DONE;
          end else if (phase_r == PH_PKTDATA && pkt_nxt == '0) begin
            phase_nxt = PH_PKTHDR;
          end
        end
      end
      PH_PKTHDR: begin
        run_nxt = data_byte[7];
        pkt_nxt = data_byte[7] ? (data_byte - 8'd127) : (data_byte + 8'd1);
        idx_nxt = '0;
        if ({24'd0, pkt_nxt} > left_r) begin
          phase_nxt = PH_ERROR;
          rec_valid = 1'b1;
          rec.kind  = KIND_ERROR;
          rec.code  = ERR_OVERRUN;
        end else begin
          phase_nxt = PH_PKTDATA;
        end
      end
      default: ;
    endcase

    if (last_byte) begin
      if (phase_nxt != PH_DONE && phase_nxt != PH_ERROR) begin
        rec_valid = 1'b1;
        rec       = '0;
        rec.kind  = KIND_ERROR;
        rec.code  = ERR_TRUNCATED;
      end
      phase_nxt  = PH_HEADER;
      idx_nxt    = '0;
      hdr_ok_nxt = 1'b1;
      comp_nxt   = 1'b0;
      width_nxt  = '0;
      height_nxt = '0;
      bpp_nxt    = '0;
      left_nxt   = '0;
      pkt_nxt    = '0;
      run_nxt    = 1'b0;
      pix_nxt    = '0;
    end
  end

endmodule

FILE: sv/tsd_queue.sv
// tsd_queue: short record queue between parser and output stage
// depends on tsd_pkg
module tsd_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tsd_pkg::rec_t push_rec,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output tsd_pkg::rec_t head_rec
);
  import tsd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rec_t          q_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_rec = q_r[rp_r];

  always_comb begin
    wp_nxt  = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    rp_nxt  = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_nxt;
      if (pop) rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_rec;
  end

endmodule

FILE: sv/tsd_back.sv
// tsd_back: output stage; formats a record into the result bus with the
// red/blue swap on colour pixels and holds it until taken. depends on tsd_pkg
module tsd_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             have_rec,
  input  tsd_pkg::rec_t                    rec,
  output logic                             take,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tsd_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [1:0]                       out_tuser,
  output logic                             out_tlast
);
  import tsd_pkg::*;

  logic                  vld_r;
  logic [OUT_DATA_W-1:0] data_r, data_nxt;
  logic [1:0]            user_r;
  logic                  last_r;

  assign take       = have_rec && (!vld_r || out_tready);
  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

  always_comb begin
    logic [7:0] b1, b2, b3, b4;
    b1 = '0;
    b2 = '0;
    b3 = '0;
    b4 = '0;
    if (rec.kind == KIND_PIXEL) begin
      if (rec.bpp == 3'd1) begin
        b1 = rec.pix[0];
      end else begin
        b1 = rec.pix[2];
        b2 = rec.pix[1];
        b3 = rec.pix[0];
        b4 = (rec.bpp == 3'd4) ? rec.pix[3] : 8'd0;
      end
    end
    data_nxt = {3'd0, rec.code, rec.count, b4, b3, b2, b1, rec.comp, rec.fmt,
                rec.height, rec.width};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= data_nxt;
      user_r <= rec.kind;
      last_r <= rec.last;
    end
  end

endmodule

FILE: sv/tsd_checker.sv
// tsd_checker: port-level assertions for the tga stream decoder
// depends on tsd_pkg; bound to tga_stream_decoder
module tsd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [tsd_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]                     out_tuser,
  input logic                           out_tlast
);
  import tsd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("undefined result kind");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == KIND_PIXEL)
    else $error("last pixel flag on non-pixel result");

  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_PIXEL |-> out_tdata[74:67] != 8'd0)
    else $error("pixel result with zero run length");

endmodule

bind tga_stream_decoder tsd_checker u_tsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
